@@ rtl/stk_pkg.sv @@
package stk_pkg;

    localparam int DEPTH   = 16;
    localparam int CAP_MAX = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int USER_W  = STAT_W + 1;

    localparam logic [CNT_W-1:0] CAP_TOP = (CAP_MAX < DEPTH) ? CNT_W'(CAP_MAX) : CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_DISPLAY = 3'd2,
        CMD_PEEK    = 3'd3,
        CMD_CHANGE  = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_UNF = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEEK,
        S_DISP
    } state_t;

    typedef struct packed {
        status_t                   status;
        logic                      data_valid;
        logic signed [DATA_W-1:0]  data;
        logic                      last;
    } res_t;

endpackage

@@ rtl/stk_obuf.sv @@
module stk_obuf
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  stk_pkg::res_t                       res,
    output logic                                res_space,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [stk_pkg::DATA_W-1:0]   m_axis_tdata,   // data
    output logic [stk_pkg::USER_W-1:0]          m_axis_tuser,   // status, data_valid
    output logic                                m_axis_tlast
);

    stk_pkg::res_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          push;
    logic          pop;
    stk_pkg::res_t head;

    assign push      = res_valid && (fill_reg != 2'd2);
    assign pop       = m_axis_tvalid && m_axis_tready;
    assign res_space = (fill_reg != 2'd2);
    assign head      = slot_reg[rd_ptr_reg];

    assign m_axis_tvalid = (fill_reg != 2'd0);
    assign m_axis_tdata  = head.data;
    assign m_axis_tuser  = {head.data_valid, head.status};
    assign m_axis_tlast  = head.last;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

@@ rtl/stk_core.sv @@
module stk_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [stk_pkg::CNT_W-1:0]           cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [stk_pkg::CMD_W-1:0]           s_axis_tuser,
    input  logic signed [stk_pkg::DATA_W-1:0]   s_axis_tdata,
    output logic                                res_valid,
    output stk_pkg::res_t                       res,
    input  logic                                res_space
);

    logic signed [stk_pkg::DATA_W-1:0] mem [stk_pkg::DEPTH];
    logic signed [stk_pkg::DATA_W-1:0] rd_data_reg;

    stk_pkg::state_t             state_reg;
    stk_pkg::state_t             state_next;
    logic [stk_pkg::CNT_W-1:0]   count_reg;
    logic [stk_pkg::CNT_W-1:0]   count_next;
    logic [stk_pkg::ADDR_W-1:0]  idx_reg;
    logic [stk_pkg::ADDR_W-1:0]  idx_next;
    logic [stk_pkg::CNT_W-1:0]   cap_reg;
    logic [stk_pkg::CNT_W-1:0]   cap_eff;
    logic [stk_pkg::CNT_W-1:0]   count_m1;
    logic                        mem_we;
    logic [stk_pkg::ADDR_W-1:0]  mem_waddr;
    logic                        mem_re;
    logic [stk_pkg::ADDR_W-1:0]  mem_raddr;
    logic                        accept;
    logic                        disp_last;
    stk_pkg::cmd_t               cmd;

    assign cap_eff   = (cap_reg > stk_pkg::CAP_TOP) ? stk_pkg::CAP_TOP : cap_reg;
    assign count_m1  = count_reg - stk_pkg::CNT_ONE;
    assign cmd       = stk_pkg::cmd_t'(s_axis_tuser);
    assign disp_last = ({1'b0, idx_reg} == count_m1);

    assign s_axis_tready = (state_reg == stk_pkg::S_IDLE) && res_space;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[stk_pkg::ADDR_W-1:0];
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;
        res_valid      = 1'b0;
        res.status     = stk_pkg::ST_OK;
        res.data_valid = 1'b0;
        res.data       = '0;
        res.last       = 1'b1;

        case (state_reg)
            stk_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        stk_pkg::CMD_PUSH:
                        begin
                            res_valid = 1'b1;
                            if (count_reg >= cap_eff)
                            begin
                                res.status = stk_pkg::ST_OVF;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + stk_pkg::CNT_ONE;
                            end
                        end
                        stk_pkg::CMD_POP:
                        begin
                            res_valid = 1'b1;
                            if (count_reg == '0)
                            begin
                                res.status = stk_pkg::ST_UNF;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        stk_pkg::CMD_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = stk_pkg::ST_UNF;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = stk_pkg::S_DISP;
                            end
                        end
                        stk_pkg::CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = stk_pkg::ST_UNF;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = count_m1[stk_pkg::ADDR_W-1:0];
                                state_next = stk_pkg::S_PEEK;
                            end
                        end
                        stk_pkg::CMD_CHANGE:
                        begin
                            res_valid = 1'b1;
                            if (count_reg == '0)
                            begin
                                res.status = stk_pkg::ST_UNF;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = count_m1[stk_pkg::ADDR_W-1:0];
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            stk_pkg::S_PEEK:
            begin
                if (res_space)
                begin
                    res_valid      = 1'b1;
                    res.data_valid = 1'b1;
                    res.data       = rd_data_reg;
                    state_next     = stk_pkg::S_IDLE;
                end
            end
            stk_pkg::S_DISP:
            begin
                if (res_space)
                begin
                    res_valid      = 1'b1;
                    res.data_valid = 1'b1;
                    res.data       = rd_data_reg;
                    res.last       = disp_last;
                    if (disp_last)
                    begin
                        state_next = stk_pkg::S_IDLE;
                    end
                    else
                    begin
                        // fetch the next entry up while this one is handed off
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + stk_pkg::ADDR_W'(1);
                        idx_next  = idx_reg + stk_pkg::ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = stk_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stk_pkg::S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            cap_reg   <= stk_pkg::CNT_W'(stk_pkg::CAP_MAX);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // entry store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= s_axis_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stk_pkg::CNT_W'(stk_pkg::DEPTH))
        else $error("stack count beyond depth");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == stk_pkg::S_IDLE))
        else $error("input taken while a read is in flight");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != stk_pkg::S_IDLE) |-> (count_reg != '0))
        else $error("read sequence on an empty stack");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_space)
        else $error("result issued into a full output buffer");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (state_next == stk_pkg::S_PEEK)) |=> (state_reg == stk_pkg::S_PEEK))
        else $error("peek sequence lost");

endmodule

@@ rtl/bounded_lifo_stack.sv @@
// bounded lifo stack of signed 32-bit words, up to 16 entries
//
// input channel s_axis: tuser carries the command (push, pop, display,
// peek, change top), tdata the value for push and change
// output channel m_axis: tdata is the entry read, tuser the status and
// the data-valid flag, tlast marks the final result of a command
// configuration: cfg_we writes cfg_wdata as the capacity limit
// (reset 16, values above 16 act as 16, zero makes every push overflow)
//
// push, pop, change and unknown commands hand their result to the output
// buffer in the cycle of the transfer, one command per cycle while it has space
// peek reads the top entry into a register first, then emits it
// display emits one entry per cycle from the bottom up while the buffer has
// space, after a registered read; input is held off meanwhile
// results go through a two-entry output buffer, so a new command is
// taken while one result still waits; a stalled receiver holds off input
// only once the buffer is full
// reset empties the stack at once; no clearing pass is needed
module bounded_lifo_stack
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [stk_pkg::CNT_W-1:0]           cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [stk_pkg::DATA_W-1:0]   s_axis_tdata,   // value
    input  logic [stk_pkg::CMD_W-1:0]           s_axis_tuser,   // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [stk_pkg::DATA_W-1:0]   m_axis_tdata,   // data
    output logic [stk_pkg::USER_W-1:0]          m_axis_tuser,   // status, data_valid
    output logic                                m_axis_tlast
);

    logic          res_valid;
    logic          res_space;
    stk_pkg::res_t res;

    stk_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .res_valid     (res_valid),
        .res           (res),
        .res_space     (res_space)
    );

    stk_obuf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .res_space     (res_space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
